// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/hidkbd_pkg.sv =====
// ----------------------------------------------------------------------------
// HID boot keyboard differ package
// Fixed constants of the boot keyboard report format and event numbering.
// ----------------------------------------------------------------------------
package hidkbd_pkg;

  // Report layout.
  localparam int unsigned MOD_BITS    = 8;
  localparam int unsigned INPUT_SLOTS = 6;

  // Event limits and usage codes.
  localparam int unsigned MAX_EVENTS     = 20;
  localparam logic [7:0]  USAGE_LOW      = 8'h04;
  localparam logic [7:0]  USAGE_HIGH     = 8'h63;
  localparam logic [7:0]  MOD_USAGE_BASE = 8'hE0;

  typedef logic [7:0] usage_t;

  // A usage in the keyboard page range gives an event; empty and error codes do not.
  function automatic logic usage_reportable(input usage_t code);
    return (code >= USAGE_LOW) && (code <= USAGE_HIGH);
  endfunction

  // Fold left and right modifiers into ctrl/shift/alt/meta.
  function automatic logic [3:0] fold_modifiers(input logic [7:0] m);
    return m[3:0] | m[7:4];
  endfunction

endpackage

// ===== rtl/core/hid_boot_keyboard_report_differ_unit.sv =====
// ----------------------------------------------------------------------------
// HID boot keyboard report differ
// Compares each boot keyboard report with the previous one and emits one
// key event beat per modifier edge, released key and pressed key.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  --------------------------------
//   in       sink       in_valid_i / in_ready_o  modifier_byte_i, key_slot_N_i
//   out      source     out_valid_o/out_ready_i  key_usage_o, is_press_o,
//                                                modifier_flags_o, last_in_run_o
//
// A report is diffed against the stored state in the cycle it is accepted and
// its event mask moves into a pending register; a priority encoder on that mask
// picks one event per cycle into the output register while the output is not
// stalled (at most 20 per report); a report with no events leaves none pending.
// The next report is accepted in the cycle the last pending event moves out.
// Reset clears the stored report and all valid flags; a stalled output holds
// the pending events and the input in turn.
module hid_boot_keyboard_report_differ_unit
  import hidkbd_pkg::*;
#(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_byte_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] key_usage_o,
  output logic       is_press_o,
  output logic [3:0] modifier_flags_o,
  output logic       last_in_run_o
);

`include "assert_macros.svh"

  // Event numbering: modifier bits, then release slots, then press slots.
  localparam int unsigned EW      = MOD_BITS + 2 * KEY_SLOTS;
  localparam int unsigned IW      = $clog2(EW);
  localparam int unsigned SLOT_IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned CW      = $clog2(MAX_EVENTS);
  localparam logic [IW-1:0] REL_BASE = IW'(MOD_BITS);
  localparam logic [IW-1:0] PRS_BASE = IW'(MOD_BITS + KEY_SLOTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_EVENTS - 1);

  // Stored previous report.
  logic [7:0] prev_mods_q;
  usage_t     prev_codes_q [KEY_SLOTS];

  // Pending events of the report being drained.
  logic          pend_valid_q, pend_valid_d;
  logic [EW-1:0] pend_mask_q, pend_mask_d;
  logic [CW-1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0]    pend_mods_q;
  usage_t        pend_rel_q [KEY_SLOTS];
  usage_t        pend_prs_q [KEY_SLOTS];

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] key_usage_q, key_usage_d;
  logic       is_press_q, is_press_d;
  logic [3:0] flags_q, flags_d;
  logic       last_q, last_d;

  logic          in_accept;
  logic          load_out;
  logic          pend_done;
  logic [EW-1:0] new_mask;
  logic [EW-1:0] rest_mask;
  logic [IW-1:0] sel_idx;
  usage_t        now_codes [KEY_SLOTS];
  usage_t        slot_in [INPUT_SLOTS];

  assign slot_in[0] = key_slot_0_i;
  assign slot_in[1] = key_slot_1_i;
  assign slot_in[2] = key_slot_2_i;
  assign slot_in[3] = key_slot_3_i;
  assign slot_in[4] = key_slot_4_i;
  assign slot_in[5] = key_slot_5_i;

  // Slots beyond the report's six bytes read as empty.
  for (genvar gi = 0; gi < KEY_SLOTS; gi++) begin : g_now
    if (gi < INPUT_SLOTS) begin : g_in
      assign now_codes[gi] = slot_in[gi];
    end else begin : g_zero
      assign now_codes[gi] = '0;
    end
  end

  // Diff of the incoming report against the stored one.
  always_comb begin
    logic found;
    new_mask = '0;
    new_mask[MOD_BITS-1:0] = modifier_byte_i ^ prev_mods_q;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (now_codes[j] == prev_codes_q[i]) begin
          found = 1'b1;
        end
      end
      new_mask[MOD_BITS + i] = !found && usage_reportable(prev_codes_q[i]);
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_codes_q[j] == now_codes[i]) begin
          found = 1'b1;
        end
      end
      new_mask[MOD_BITS + KEY_SLOTS + i] = !found && usage_reportable(now_codes[i]);
    end
  end

  // Lowest pending event goes first.
  always_comb begin
    sel_idx = '0;
    for (int k = EW - 1; k >= 0; k--) begin
      if (pend_mask_q[k]) begin
        sel_idx = IW'(k);
      end
    end
  end

  assign rest_mask = pend_mask_q & (pend_mask_q - EW'(1));

  // Handshake control.
  assign load_out   = pend_valid_q && (!out_valid_q || out_ready_i);
  assign pend_done  = load_out && ((rest_mask == '0) || (pend_cnt_q == CNT_LAST));
  assign in_ready_o = !pend_valid_q || pend_done;
  assign in_accept  = in_valid_i && in_ready_o;

  // Pending register next state.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_mask_d  = pend_mask_q;
    pend_cnt_d   = pend_cnt_q;
    if (in_accept) begin
      pend_valid_d = (new_mask != '0);
      pend_mask_d  = new_mask;
      pend_cnt_d   = '0;
    end else if (load_out) begin
      pend_valid_d = !pend_done;
      pend_mask_d  = rest_mask;
      pend_cnt_d   = pend_cnt_q + CW'(1);
    end
  end

  // Build the selected event beat.
  always_comb begin
    logic [IW-1:0] rel_off;
    logic [IW-1:0] prs_off;
    rel_off     = sel_idx - REL_BASE;
    prs_off     = sel_idx - PRS_BASE;
    out_valid_d = out_valid_q;
    key_usage_d = key_usage_q;
    is_press_d  = is_press_q;
    flags_d     = flags_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      flags_d     = fold_modifiers(pend_mods_q);
      last_d      = pend_done;
      if (sel_idx < REL_BASE) begin
        key_usage_d = MOD_USAGE_BASE | {5'b0, sel_idx[2:0]};
        is_press_d  = pend_mods_q[sel_idx[2:0]];
      end else if (sel_idx < PRS_BASE) begin
        key_usage_d = pend_rel_q[rel_off[SLOT_IW-1:0]];
        is_press_d  = 1'b0;
      end else begin
        key_usage_d = pend_prs_q[prs_off[SLOT_IW-1:0]];
        is_press_d  = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_mask_q  <= '0;
      pend_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      prev_mods_q  <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_codes_q[i] <= '0;
      end
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_mask_q  <= pend_mask_d;
      pend_cnt_q   <= pend_cnt_d;
      out_valid_q  <= out_valid_d;
      if (in_accept) begin
        prev_mods_q <= modifier_byte_i;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          prev_codes_q[i] <= now_codes[i];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_usage_q <= key_usage_d;
    is_press_q  <= is_press_d;
    flags_q     <= flags_d;
    last_q      <= last_d;
    if (in_accept) begin
      pend_mods_q <= modifier_byte_i;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        pend_rel_q[i] <= prev_codes_q[i];
        pend_prs_q[i] <= now_codes[i];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_usage_o      = key_usage_q;
  assign is_press_o       = is_press_q;
  assign modifier_flags_o = flags_q;
  assign last_in_run_o    = last_q;

  // Assertions.
  `ASSERT_ON(a_pend_nonempty, clk_i, rst_ni, pend_valid_q |-> (pend_mask_q != '0), "pending report has no events")
  `ASSERT_ON(a_accept_loads, clk_i, rst_ni, (in_accept && (new_mask != '0)) |=> pend_valid_q, "report with events was not queued")
  `ASSERT_ON(a_cnt_bound, clk_i, rst_ni, pend_valid_q |-> (pend_cnt_q <= CNT_LAST), "event count beyond limit")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!out_valid_q && !pend_valid_q), "valid flags set in reset")

endmodule

// ===== bench/hid_boot_keyboard_report_differ_unit_tb.sv =====
// ----------------------------------------------------------------------------
// HID boot keyboard report differ testbench
// Sends boot keyboard reports into the differ and checks every key event beat
// against a scoreboard that diffs each report against the one before it.
// Both channels idle at random, the receiver holds off once for a long stretch,
// and the sender drains the block completely at a few points in the run.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_differ_unit_tb;
  import hidkbd_pkg::*;

  localparam int unsigned KEY_SLOTS      = 6;
  localparam int unsigned RANDOM_REPORTS = 180;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned RUN_LIMIT      = 1000000;
  localparam int unsigned SHOWN_FAILS    = 10;

  typedef usage_t slot_set_t [KEY_SLOTS];

  // One key event beat as it leaves the block.
  typedef struct packed {
    usage_t     usage;
    logic       press;
    logic [3:0] flags;
    logic       last;
  } key_event_t;

  // Keeps the previous report and the key events still owed by the block.
  class key_event_board;
    logic [7:0] held_mods;
    usage_t     held_codes [KEY_SLOTS];
    key_event_t waiting [$];
    int unsigned fails;
    int unsigned n_reports;
    int unsigned n_quiet;
    int unsigned n_presses;
    int unsigned n_releases;
    int unsigned busiest;

    function new();
      held_mods = '0;
      foreach (held_codes[i]) held_codes[i] = '0;
      fails      = 0;
      n_reports  = 0;
      n_quiet    = 0;
      n_presses  = 0;
      n_releases = 0;
      busiest    = 0;
    endfunction

    function bit in_key_page(usage_t code);
      return code >= USAGE_LOW && code <= USAGE_HIGH;
    endfunction

    function bit holds(usage_t list [KEY_SLOTS], usage_t code);
      foreach (list[i]) if (list[i] == code) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned pending();
      return waiting.size();
    endfunction

    function void note_fail(string what);
      fails++;
      if (fails <= SHOWN_FAILS) $display("%s", what);
    endfunction

    // Diffs an accepted report against the held one and queues its events.
    function void note_report(logic [7:0] mods, slot_set_t codes);
      key_event_t run [$];
      key_event_t ev;
      logic [3:0] flags;
      flags = mods[3:0] | mods[7:4];
      ev.flags = flags;
      ev.last  = 1'b0;
      // Modifier edges first, lowest bit first.
      for (int b = 0; b < 8; b++) begin
        if (mods[b] != held_mods[b]) begin
          ev.usage = MOD_USAGE_BASE + 8'(b);
          ev.press = mods[b];
          run.push_back(ev);
        end
      end
      // Releases of codes that left the report, in slot order.
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (!holds(codes, held_codes[i]) && in_key_page(held_codes[i])) begin
          ev.usage = held_codes[i];
          ev.press = 1'b0;
          run.push_back(ev);
        end
      end
      // Presses of codes that are new, in slot order.
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (!holds(held_codes, codes[i]) && in_key_page(codes[i])) begin
          ev.usage = codes[i];
          ev.press = 1'b1;
          run.push_back(ev);
        end
      end
      while (run.size() > MAX_EVENTS) void'(run.pop_back());
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      else n_quiet++;
      if (run.size() > busiest) busiest = run.size();
      foreach (run[i]) waiting.push_back(run[i]);
      held_mods = mods;
      held_codes = codes;
      n_reports++;
    endfunction

    // Compares one output beat with the oldest owed event.
    function void check_event(key_event_t got);
      key_event_t want;
      if (waiting.size() == 0) begin
        note_fail($sformatf("Unexpected beat: usage %h press %0b flags %h last %0b",
                            got.usage, got.press, got.flags, got.last));
        return;
      end
      want = waiting.pop_front();
      if (got.press) n_presses++;
      else n_releases++;
      if (got.usage !== want.usage || got.press !== want.press ||
          got.flags !== want.flags || got.last !== want.last) begin
        note_fail($sformatf({"Mismatch: expected usage %h press %0b flags %h last %0b,",
                             " got usage %h press %0b flags %h last %0b"},
                            want.usage, want.press, want.flags, want.last,
                            got.usage, got.press, got.flags, got.last));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready_o;
  logic [7:0] modifier_byte;
  usage_t     key_slot [KEY_SLOTS];
  logic       out_valid_o;
  logic       out_ready;
  logic [7:0] key_usage_o;
  logic       is_press_o;
  logic [3:0] modifier_flags_o;
  logic       last_in_run_o;

  key_event_board board = new();

  // Shared controls between the sender and the receiver.
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;
  int unsigned rx_stall;

  // Last report sent, the base for the next random one.
  logic [7:0] cur_mods;
  slot_set_t  cur_codes;

  hid_boot_keyboard_report_differ_unit #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .modifier_byte_i (modifier_byte),
    .key_slot_0_i    (key_slot[0]),
    .key_slot_1_i    (key_slot[1]),
    .key_slot_2_i    (key_slot[2]),
    .key_slot_3_i    (key_slot[3]),
    .key_slot_4_i    (key_slot[4]),
    .key_slot_5_i    (key_slot[5]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .key_usage_o     (key_usage_o),
    .is_press_o      (is_press_o),
    .modifier_flags_o(modifier_flags_o),
    .last_in_run_o   (last_in_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("[hid_boot_keyboard_report_differ_unit] ERROR");
    $finish;
  end

  // Offers one report and holds it until the block takes the beat.
  task automatic send_report(input logic [7:0] mods, input slot_set_t codes);
    in_valid      <= 1'b1;
    modifier_byte <= mods;
    for (int i = 0; i < KEY_SLOTS; i++) key_slot[i] <= codes[i];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_report(mods, codes);
    cur_mods  = mods;
    cur_codes = codes;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Stops offering reports until every owed event has come out.
  task automatic drain_all(input int unsigned limit);
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && n < limit) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // Builds the next random report, mostly as a plausible change of the last one.
  task automatic make_report(output logic [7:0] mods, output slot_set_t codes);
    int unsigned pick;
    int unsigned s;
    int unsigned c;
    mods  = cur_mods;
    codes = cur_codes;
    pick  = $urandom_range(0, 99);
    if (pick < 6) begin
      // Same report again.
    end else if (pick < 14) begin
      mods = 8'($urandom_range(0, 255));
      foreach (codes[i]) codes[i] = 8'($urandom_range(0, 255));
    end else if (pick < 17) begin
      // Phantom state: every slot reports rollover.
      foreach (codes[i]) codes[i] = 8'h01;
    end else begin
      repeat ($urandom_range(0, 2)) mods[$urandom_range(0, 7)] ^= 1'b1;
      repeat ($urandom_range(0, 3)) begin
        s = $urandom_range(0, KEY_SLOTS - 1);
        c = $urandom_range(0, 9);
        if (c < 3) codes[s] = 8'h00;
        else if (c < 5) codes[s] = USAGE_LOW + 8'($urandom_range(0, 5));
        else if (c < 9) codes[s] = 8'($urandom_range(USAGE_LOW, USAGE_HIGH));
        else codes[s] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  // Receiver: checks accepted beats and paces out_ready.
  initial begin : rx_side
    key_event_t got;
    out_ready <= 1'b0;
    rx_stall  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        got.usage = key_usage_o;
        got.press = is_press_o;
        got.flags = modifier_flags_o;
        got.last  = last_in_run_o;
        board.check_event(got);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall    = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_stall  = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender and run control.
  initial begin : tx_side
    logic [7:0] mods;
    slot_set_t  codes;
    rst_ni        = 1'b0;
    in_valid      <= 1'b0;
    modifier_byte <= '0;
    for (int i = 0; i < KEY_SLOTS; i++) key_slot[i] <= '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b0;
    cur_mods    = '0;
    foreach (cur_codes[i]) cur_codes[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed reports: empty start, modifier sides, the fullest diff,
    // rollover codes, range edges and repeated codes.
    codes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_report(8'h00, codes);
    send_report(8'h01, codes);
    send_report(8'h10, codes);
    codes = '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    send_report(8'hFF, codes);
    send_report(8'hFF, codes);
    codes = '{8'h63, 8'h62, 8'h1D, 8'h1E, 8'h27, 8'h28};
    send_report(8'h00, codes);
    codes = '{8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01};
    send_report(8'h00, codes);
    codes = '{8'h00, 8'h03, 8'h64, 8'hFF, 8'hE0, 8'h80};
    send_report(8'h00, codes);
    codes = '{8'h04, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00};
    send_report(8'hAA, codes);
    codes = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00};
    send_report(8'h55, codes);
    codes = '{8'h03, 8'h04, 8'h63, 8'h64, 8'h00, 8'h00};
    send_report(8'hF0, codes);
    codes = '{8'h63, 8'h63, 8'h04, 8'h04, 8'h63, 8'h04};
    send_report(8'h0F, codes);
    codes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_report(8'h80, codes);
    codes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_report(8'h00, codes);
    drain_all(RUN_LIMIT);

    // Random reports, with a long receiver hold and a full drain midway.
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      tx_idle_en = (n < RANDOM_REPORTS - 30) && !(n >= 60 && n < 80);
      rx_idle_en = (n < RANDOM_REPORTS - 30);
      if (n == 60) rx_hold_req = 1'b1;
      if (n == 120) drain_all(RUN_LIMIT);
      make_report(mods, codes);
      send_report(mods, codes);
    end

    drain_all(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      board.note_fail($sformatf("%0d key events never came out", board.pending()));
    end

    $display("Sent %0d reports (%0d with no events, at most %0d events from one).",
             board.n_reports, board.n_quiet, board.busiest);
    $display("Checked %0d presses and %0d releases under random stalls; %0d failures.",
             board.n_presses, board.n_releases, board.fails);
    if (board.fails == 0) begin
      $display("[hid_boot_keyboard_report_differ_unit] OK");
    end else begin
      $display("[hid_boot_keyboard_report_differ_unit] ERROR");
    end
    $finish;
  end

endmodule
